// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the memory configuration chain
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock out of reset
`define MCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition that must be followed by a consequence on the following clock
`define MCC_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg
// types, codes and tables of the memory configuration chain
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

  // slots described by the module table
  localparam int TABLE_SLOTS = 6;
  localparam int ID_ENTRIES  = 2 * TABLE_SLOTS;

  localparam int WORD_W = 20;
  localparam int CODE_W = 12;
  localparam int IDX_W  = 3;
  localparam int CNT_W  = 2;
  localparam int KEY_W  = 4;

  // slot index reported when no slot is affected
  localparam logic [IDX_W-1:0] NONE_INDEX = 3'd6;

  typedef enum logic [1:0] {
    FUNC_RESET    = 2'd0,
    FUNC_CONFIG   = 2'd1,
    FUNC_UNCONFIG = 2'd2,
    FUNC_IDENTIFY = 2'd3
  } mcc_func_t;

  typedef struct packed {
    mcc_func_t         func;
    logic [WORD_W-1:0] conf_value;
  } mcc_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] chip_code;
    logic              slot_hit;
    logic [IDX_W-1:0]  slot_index;
  } mcc_out_t;

  // request from the pipeline to the slot bank
  typedef struct packed {
    logic    fire;
    mcc_in_t item;
  } mcc_req_t;

  localparam logic [CNT_W-1:0] RESET_COUNTS [0:TABLE_SLOTS-1] = '{
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0
  };

  localparam logic [CODE_W-1:0] ID_TABLE [0:ID_ENTRIES-1] = '{
    12'h000, 12'h000, 12'h000, 12'h000, 12'h005, 12'h0f6,
    12'h007, 12'h0f8, 12'h001, 12'h0f2, 12'h000, 12'h000
  };

  // chip id for a two-entries-per-slot key, zero past the table
  function automatic logic [CODE_W-1:0] chip_id(input logic [KEY_W-1:0] key);
    logic [CODE_W-1:0] code;
    code = '0;
    if (key < KEY_W'(ID_ENTRIES)) begin
      code = ID_TABLE[key];
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// File: design/mcc_slot_bank.sv
// ----------------------------------------------------------------------------
// mcc_slot_bank
// slot state, priority search and registered update per item
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_slot_bank #(
  parameter int LIVE_SLOTS = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mcc_pkg::mcc_req_t req,
  output mcc_pkg::mcc_out_t     rsp
);

  logic [mcc_pkg::CNT_W-1:0]  pend_r [LIVE_SLOTS];
  logic [mcc_pkg::WORD_W-1:0] base_r [LIVE_SLOTS];

  logic                       pend_hit;
  logic [mcc_pkg::IDX_W-1:0]  pend_idx;
  logic [mcc_pkg::CNT_W-1:0]  pend_cnt;
  logic [mcc_pkg::CNT_W-1:0]  pend_cnt_dec;
  logic                       match_hit;
  logic [mcc_pkg::IDX_W-1:0]  match_idx;
  logic [mcc_pkg::KEY_W-1:0]  id_key;

  // first pending slot and first slot whose base matches, lowest index wins
  always_comb begin
    pend_hit  = 1'b0;
    pend_idx  = mcc_pkg::NONE_INDEX;
    pend_cnt  = '0;
    match_hit = 1'b0;
    match_idx = mcc_pkg::NONE_INDEX;
    for (int i = LIVE_SLOTS - 1; i >= 0; i--) begin
      if (pend_r[i] != '0) begin
        pend_hit = 1'b1;
        pend_idx = mcc_pkg::IDX_W'(i);
        pend_cnt = pend_r[i];
      end
      if (base_r[i] == req.item.conf_value) begin
        match_hit = 1'b1;
        match_idx = mcc_pkg::IDX_W'(i);
      end
    end
  end

  assign pend_cnt_dec = pend_cnt - 2'd1;

  // id key: two entries per slot, second entry once the size step is done
  assign id_key = {pend_idx, (pend_cnt == 2'd1)};

  // result of the item
  always_comb begin
    rsp.chip_code  = '0;
    rsp.slot_hit   = 1'b0;
    rsp.slot_index = mcc_pkg::NONE_INDEX;
    unique case (req.item.func)
      mcc_pkg::FUNC_RESET: begin
      end
      mcc_pkg::FUNC_CONFIG: begin
        rsp.slot_hit   = pend_hit;
        rsp.slot_index = pend_idx;
      end
      mcc_pkg::FUNC_UNCONFIG: begin
        rsp.slot_hit   = match_hit;
        rsp.slot_index = match_idx;
      end
      mcc_pkg::FUNC_IDENTIFY: begin
        rsp.slot_hit   = pend_hit;
        rsp.slot_index = pend_idx;
        if (pend_hit) begin
          rsp.chip_code = mcc_pkg::chip_id(id_key);
        end
      end
    endcase
  end

  // slot state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LIVE_SLOTS; i++) begin
        pend_r[i] <= mcc_pkg::RESET_COUNTS[i];
        base_r[i] <= '0;
      end
    end else if (req.fire) begin
      unique case (req.item.func)
        mcc_pkg::FUNC_RESET: begin
          for (int i = 0; i < LIVE_SLOTS; i++) begin
            pend_r[i] <= mcc_pkg::RESET_COUNTS[i];
            base_r[i] <= '0;
          end
        end
        mcc_pkg::FUNC_CONFIG: begin
          // size goes first and is not read back; base lands on the last step
          for (int i = 0; i < LIVE_SLOTS; i++) begin
            if (pend_hit && (pend_idx == mcc_pkg::IDX_W'(i))) begin
              pend_r[i] <= pend_cnt_dec;
              if (pend_cnt_dec == '0) begin
                base_r[i] <= req.item.conf_value;
              end
            end
          end
        end
        mcc_pkg::FUNC_UNCONFIG: begin
          for (int i = 0; i < LIVE_SLOTS; i++) begin
            if (match_hit && (match_idx == mcc_pkg::IDX_W'(i))) begin
              pend_r[i] <= mcc_pkg::RESET_COUNTS[i];
              base_r[i] <= '0;
            end
          end
        end
        mcc_pkg::FUNC_IDENTIFY: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/memory_config_chain.sv
// Memory configuration chain: a daisy chain of module slots that are sized,
// based, released and identified one item at a time. Each item passes an
// input register, is resolved against the slot state combinationally and
// lands in a result register. One item can be taken every cycle unless
// out_stall holds both registers full; the per-item update of the slot
// registers sets that rate. Slots past the sixth are never used.
// ----------------------------------------------------------------------------
// memory_config_chain
// top level: input register, slot bank and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module memory_config_chain #(
  parameter int NUM_SLOTS = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mcc_pkg::mcc_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mcc_pkg::mcc_out_t      out_data
);

  localparam int LIVE_SLOTS =
    (NUM_SLOTS < mcc_pkg::TABLE_SLOTS) ? NUM_SLOTS : mcc_pkg::TABLE_SLOTS;

  logic              q_valid_r;
  logic              q_valid_nxt;
  mcc_pkg::mcc_in_t  q_item_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  mcc_pkg::mcc_out_t out_data_r;
  logic              in_take;
  logic              q_adv;
  mcc_pkg::mcc_req_t bank_req;
  mcc_pkg::mcc_out_t bank_rsp;

  // handshake
  assign q_adv         = q_valid_r && (!out_valid_r || !out_stall);
  assign in_stall      = q_valid_r && !q_adv;
  assign in_take       = in_valid && !in_stall;
  assign q_valid_nxt   = in_take || (q_valid_r && !q_adv);
  assign out_valid_nxt = q_adv || (out_valid_r && out_stall);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      q_valid_r   <= q_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input and result payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      q_item_r <= in_data;
    end
    if (q_adv) begin
      out_data_r <= bank_rsp;
    end
  end

  assign bank_req.fire = q_adv;
  assign bank_req.item = q_item_r;

  mcc_slot_bank #(
    .LIVE_SLOTS (LIVE_SLOTS)
  ) u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (bank_req),
    .rsp   (bank_rsp)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `MCC_ASSERT(a_hit_index, !out_valid_r ||
    (out_data_r.slot_hit == (out_data_r.slot_index != mcc_pkg::NONE_INDEX)))
  `MCC_ASSERT(a_code_needs_hit, !out_valid_r || (out_data_r.chip_code == '0) ||
    out_data_r.slot_hit)
  `MCC_ASSERT_NEXT(a_adv_gives_result, q_adv, out_valid_r)
  `MCC_ASSERT(a_stall_when_full, !in_stall || (q_valid_r && out_valid_r && out_stall))

endmodule

`default_nettype wire
